@@ sv/lcc_pkg.sv @@
// Shared constants, types and a helper function for the Luhn card number checker.
package lcc_pkg;

    // Width of the binary card number and of the decimal digit register.
    localparam int BIN_W      = 54;
    localparam int NUM_DIGITS = 17;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(BIN_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // Largest digit count that can still be classified.
    localparam int MAX_DIGITS = 16;

    // Digit counts that select an issuer class.
    localparam int LEN_PFX3X       = 15;
    localparam int LEN_PFX5X       = 16;
    localparam int LEN_PFX4_SHORT  = 13;
    localparam int LEN_PFX4_LONG   = 16;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_FINISH
    } lcc_state_t;

    // Issuer class codes.
    typedef enum logic [1:0] {
        ISSUER_NONE  = 2'd0,
        ISSUER_PFX3X = 2'd1,
        ISSUER_PFX5X = 2'd2,
        ISSUER_PFX4  = 2'd3
    } issuer_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic convert;
        logic scan;
        logic finish;
    } lcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic scan_last;
    } lcc_status_t;

    // Luhn contribution of one digit: odd positions are doubled, minus 9 above 9.
    function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic odd);
        logic [4:0] dbl;
        dbl = {d, 1'b0};
        if (!odd)
        begin
            return d;
        end
        if (dbl > 5'd9)
        begin
            dbl = dbl - 5'd9;
        end
        return dbl[3:0];
    endfunction

endpackage

@@ sv/lcc_if.sv @@
// Valid/ready channel interfaces for card number beats and result beats.
interface lcc_in_if
    import lcc_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface lcc_out_if
    import lcc_pkg::*;
    ;
    logic       valid;
    logic       ready;
    logic [1:0] issuer_class;
    logic       checksum_ok;

    modport source (output valid, output issuer_class, output checksum_ok, input ready);
    modport sink   (input valid, input issuer_class, input checksum_ok, output ready);
endinterface

@@ sv/luhn_card_number_check_core.sv @@
// Top level of the Luhn card number checker.
// Each beat on card carries a 54-bit binary card number; one beat on result follows with the
// issuer class and the Luhn checksum flag. From acceptance to its result an item passes
// through bit-serial binary to decimal conversion (one input bit per cycle into a 17-digit
// decimal register), a scan of one decimal digit per cycle for the Luhn sum, digit count and
// leading digits, and a finish step that registers the result once the result register is
// free. Numbers are worked on one at a time; the next number can be accepted once the
// previous result is registered, even if that result beat is still waiting on result.ready.
// Numbers above MAX_DIGITS digits, zero, and numbers whose checksum fails give issuer
// class 0; checksum_ok always reports the Luhn sum over all digits.
module luhn_card_number_check_core
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS
)
(
    input logic       clk,
    input logic       rst_n,
    lcc_in_if.sink    card,
    lcc_out_if.source result
);

    lcc_cmd_t    cmd;
    lcc_status_t status;

    // Sequencing of one item at a time.
    lcc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (card.valid),
        .out_ready (result.ready),
        .status    (status),
        .in_ready  (card.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    // Conversion, Luhn sum and classification.
    lcc_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk          (clk),
        .card_number  (card.card_number),
        .cmd          (cmd),
        .status       (status),
        .issuer_class (result.issuer_class),
        .checksum_ok  (result.checksum_ok)
    );

`ifndef SYNTH
    // A number is worked on alone: no second beat right after an accepted one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (card.valid && card.ready) |=> !card.ready)
        else $error("card accepted in back-to-back cycles");

    // A nonzero issuer class is only given for a passing checksum.
    a_class_needs_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.issuer_class == ISSUER_NONE || result.checksum_ok))
        else $error("issuer class set with failing checksum");

    // A new result beat never appears while a number is still being accepted.
    a_no_result_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (card.valid && card.ready) |=> !$rose(result.valid))
        else $error("result beat raised right after a card beat");
`endif

endmodule

@@ sv/lcc_datapath.sv @@
// Datapath: serial binary to decimal conversion, Luhn digit scan and classification.
module lcc_datapath
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS
)
(
    input  logic             clk,
    input  logic [BIN_W-1:0] card_number,
    input  lcc_cmd_t         cmd,
    output lcc_status_t      status,
    output logic [1:0]       issuer_class,
    output logic             checksum_ok
);

    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [DIG_CNT_W-1:0] count_reg, count_next;
    logic [3:0]           sum_reg, sum_next;
    logic [3:0]           lead_reg, lead_next;
    logic [3:0]           second_reg, second_next;
    logic [3:0]           prev_reg, prev_next;
    logic [1:0]           issuer_class_reg, issuer_class_next;
    logic                 checksum_ok_reg, checksum_ok_next;
    logic [3:0]           digit;
    logic [3:0]           term;
    logic [4:0]           sum_wide;
    logic                 sum_ok;
    issuer_t              cls;

    // Double-dabble correction: every decimal digit of 5 or more gets 3 added.
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // Luhn term of the digit at the bottom of the decimal register, summed modulo ten.
    always_comb
    begin
        digit    = bcd_reg[3:0];
        term     = luhn_term(digit, dig_cnt_reg[0]);
        sum_wide = {1'b0, sum_reg} + {1'b0, term};
        if (sum_wide >= 5'd10)
        begin
            sum_wide = sum_wide - 5'd10;
        end
    end

    // Issuer classification from digit count and the two leading digits.
    always_comb
    begin
        sum_ok = (sum_reg == 4'd0);
        cls    = ISSUER_NONE;
        if (sum_ok && count_reg >= DIG_CNT_W'(2) && count_reg <= DIG_CNT_W'(MAX_DIGITS))
        begin
            if (count_reg == DIG_CNT_W'(LEN_PFX3X) && lead_reg == 4'd3
                && (second_reg == 4'd4 || second_reg == 4'd7))
            begin
                cls = ISSUER_PFX3X;
            end
            else if (count_reg == DIG_CNT_W'(LEN_PFX5X) && lead_reg == 4'd5
                     && second_reg >= 4'd1 && second_reg <= 4'd5)
            begin
                cls = ISSUER_PFX5X;
            end
            else if ((count_reg == DIG_CNT_W'(LEN_PFX4_SHORT)
                      || count_reg == DIG_CNT_W'(LEN_PFX4_LONG)) && lead_reg == 4'd4)
            begin
                cls = ISSUER_PFX4;
            end
        end
    end

    // Next values of the working registers under the controller's commands.
    always_comb
    begin
        bin_next          = bin_reg;
        bcd_next          = bcd_reg;
        bit_cnt_next      = bit_cnt_reg;
        dig_cnt_next      = dig_cnt_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        lead_next         = lead_reg;
        second_next       = second_reg;
        prev_next         = prev_reg;
        issuer_class_next = issuer_class_reg;
        checksum_ok_next  = checksum_ok_reg;
        if (cmd.load)
        begin
            bin_next     = card_number;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = '0;
            count_next   = '0;
            sum_next     = '0;
            lead_next    = '0;
            second_next  = '0;
            prev_next    = '0;
        end
        else if (cmd.convert)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next     = {bin_reg[BIN_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        else if (cmd.scan)
        begin
            bcd_next     = {4'd0, bcd_reg[BCD_W-1:4]};
            sum_next     = sum_wide[3:0];
            prev_next    = digit;
            dig_cnt_next = dig_cnt_reg + 1'b1;
            // The highest nonzero digit so far sets the length and the leading pair.
            if (digit != 4'd0)
            begin
                count_next  = dig_cnt_reg + 1'b1;
                lead_next   = digit;
                second_next = prev_reg;
            end
        end
        else if (cmd.finish)
        begin
            issuer_class_next = cls;
            checksum_ok_next  = sum_ok;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        bin_reg          <= bin_next;
        bcd_reg          <= bcd_next;
        bit_cnt_reg      <= bit_cnt_next;
        dig_cnt_reg      <= dig_cnt_next;
        count_reg        <= count_next;
        sum_reg          <= sum_next;
        lead_reg         <= lead_next;
        second_reg       <= second_next;
        prev_reg         <= prev_next;
        issuer_class_reg <= issuer_class_next;
        checksum_ok_reg  <= checksum_ok_next;
    end

    // Status and result outputs.
    assign status.conv_last = (bit_cnt_reg == BIT_CNT_W'(BIN_W - 1));
    assign status.scan_last = (dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS - 1));
    assign issuer_class     = issuer_class_reg;
    assign checksum_ok      = checksum_ok_reg;

endmodule

@@ sv/lcc_controller.sv @@
// Controller: sequences load, conversion, digit scan and the result handoff.
module lcc_controller
    import lcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_ready,
    input  lcc_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output lcc_cmd_t    cmd
);

    lcc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The result register can take a new beat when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.conv_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.convert = 1'b0;
        cmd.scan    = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.convert = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result beat valid flag.
    assign out_valid_next = cmd.finish || (out_valid_reg && !out_ready);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ dv/tb_luhn_card_number_check_core.sv @@
// Self-checking testbench for the Luhn card number checker: random and directed card numbers.
module tb_luhn_card_number_check_core;
    import lcc_pkg::*;

    // Leading digit values that select an issuer class.
    localparam int PFX3X_LOW  = 34;
    localparam int PFX3X_HIGH = 37;
    localparam int PFX5X_LOW  = 51;
    localparam int PFX5X_HIGH = 55;
    localparam int PFX4_LEAD  = 4;

    // Traffic shaping: idle rate, a stretch with no idling, and two long result stalls.
    localparam int IDLE_PCT     = 25;
    localparam int CALM_FROM    = 20000;
    localparam int CALM_TO      = 40000;
    localparam int HOLD_AT_A    = 6000;
    localparam int HOLD_AT_B    = 70000;
    localparam int HOLD_LEN     = 500;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        issuer_t issuer_class;
        logic    checksum_ok;
    } verdict_t;

    logic clk;
    logic rst_n;

    lcc_in_if  card_bus ();
    lcc_out_if result_bus ();

    luhn_card_number_check_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .card   (card_bus),
        .result (result_bus)
    );

    logic [BIN_W-1:0] card_queue[$];
    verdict_t         expected_verdicts[$];
    int               cycle_count;
    int               hold_left;
    int               mismatch_count = 0;
    int               results_checked = 0;
    int               checksum_fails = 0;
    int               class_seen[4] = '{default: 0};
    logic             idle_on;

    // Luhn check and issuer classification of one card number.
    function automatic verdict_t card_verdict(input logic [BIN_W-1:0] num);
        longint unsigned n;
        int              dig[24];
        int              cnt;
        int              sum;
        int              d;
        int              lead;
        int              pair;
        verdict_t        v;
        n   = num;
        cnt = 0;
        sum = 0;
        while (n != 0)
        begin
            d = int'(n % 10);
            dig[cnt] = d;
            if (cnt % 2 == 1)
            begin
                d = d * 2;
                if (d > 9)
                begin
                    d = d - 9;
                end
            end
            sum = sum + d;
            n   = n / 10;
            cnt = cnt + 1;
        end
        v.checksum_ok  = (sum % 10 == 0);
        v.issuer_class = ISSUER_NONE;
        if (v.checksum_ok && cnt >= 2 && cnt <= MAX_DIGITS)
        begin
            lead = dig[cnt-1];
            pair = lead * 10 + dig[cnt-2];
            if (cnt == LEN_PFX3X && (pair == PFX3X_LOW || pair == PFX3X_HIGH))
            begin
                v.issuer_class = ISSUER_PFX3X;
            end
            else if (cnt == LEN_PFX5X && pair >= PFX5X_LOW && pair <= PFX5X_HIGH)
            begin
                v.issuer_class = ISSUER_PFX5X;
            end
            else if ((cnt == LEN_PFX4_SHORT || cnt == LEN_PFX4_LONG) && lead == PFX4_LEAD)
            begin
                v.issuer_class = ISSUER_PFX4;
            end
        end
        return v;
    endfunction

    // Builds a number of the given length from a prefix and random digits; the final digit
    // either completes a passing checksum or is chosen to break it.
    function automatic logic [BIN_W-1:0] make_card(input longint unsigned prefix,
                                                   input int pfx_len, input int len,
                                                   input bit good);
        longint unsigned n;
        int              good_digit;
        int              last;
        n = prefix;
        good_digit = 0;
        for (int i = pfx_len; i < len - 1; i++)
        begin
            n = n * 10 + $urandom_range(0, 9);
        end
        for (int c = 0; c < 10; c++)
        begin
            if (card_verdict(BIN_W'(n * 10 + c)).checksum_ok)
            begin
                good_digit = c;
            end
        end
        last = good ? good_digit : (good_digit + $urandom_range(1, 9)) % 10;
        return BIN_W'(n * 10 + last);
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle count and the window in which idling is switched off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
            idle_on     <= 1'b1;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            idle_on     <= !(cycle_count >= CALM_FROM && cycle_count < CALM_TO);
        end
    end

    // Card number driver; the expectation is formed at the beat on card.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_bus.valid       <= 1'b0;
            card_bus.card_number <= '0;
        end
        else
        begin
            if (card_bus.valid && card_bus.ready)
            begin
                expected_verdicts.push_back(card_verdict(card_bus.card_number));
            end
            if (!card_bus.valid || card_bus.ready)
            begin
                if (card_queue.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    card_bus.valid       <= 1'b1;
                    card_bus.card_number <= card_queue.pop_front();
                end
                else
                begin
                    card_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus two long hold-offs that back up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= 0;
        end
        else if (hold_left != 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= hold_left - 1;
        end
        else if (cycle_count == HOLD_AT_A || cycle_count == HOLD_AT_B)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= HOLD_LEN;
        end
        else
        begin
            result_bus.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result monitor: each result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: class %0d ok %0b",
                         $time, result_bus.issuer_class, result_bus.checksum_ok);
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                results_checked++;
                class_seen[want.issuer_class]++;
                if (!want.checksum_ok)
                begin
                    checksum_fails++;
                end
                if (result_bus.issuer_class !== want.issuer_class)
                begin
                    $display("%0t: issuer_class expected %0d actual %0d", $time,
                             want.issuer_class, result_bus.issuer_class);
                    mismatch_count++;
                end
                if (result_bus.checksum_ok !== want.checksum_ok)
                begin
                    $display("%0t: checksum_ok expected %0b actual %0b", $time,
                             want.checksum_ok, result_bus.checksum_ok);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int              kind;
        int              len;
        bit              good;
        longint unsigned raw;
        rst_n = 1'b0;

        // Directed: zero, field extremes, too many digits, each class and its near misses.
        card_queue.push_back('0);
        card_queue.push_back(BIN_W'(1));
        card_queue.push_back(BIN_W'(18));
        card_queue.push_back({BIN_W{1'b1}});
        card_queue.push_back(BIN_W'(64'd1) << (BIN_W - 1));
        card_queue.push_back(BIN_W'(64'd9_999_999_999_999_999));
        card_queue.push_back(BIN_W'(64'd10_000_000_000_000_000));
        card_queue.push_back(make_card(10, 2, 17, 1'b1));
        card_queue.push_back(make_card(PFX3X_LOW, 2, 15, 1'b1));
        card_queue.push_back(make_card(PFX3X_HIGH, 2, 15, 1'b1));
        card_queue.push_back(make_card(PFX3X_LOW, 2, 15, 1'b0));
        card_queue.push_back(make_card(PFX3X_LOW, 2, 14, 1'b1));
        card_queue.push_back(make_card(PFX3X_HIGH, 2, 16, 1'b1));
        card_queue.push_back(make_card(PFX5X_LOW, 2, 16, 1'b1));
        card_queue.push_back(make_card(PFX5X_HIGH, 2, 16, 1'b1));
        card_queue.push_back(make_card(PFX5X_HIGH, 2, 16, 1'b0));
        card_queue.push_back(make_card(PFX5X_LOW - 1, 2, 16, 1'b1));
        card_queue.push_back(make_card(PFX5X_HIGH + 1, 2, 16, 1'b1));
        card_queue.push_back(make_card(PFX4_LEAD, 1, 16, 1'b1));
        card_queue.push_back(make_card(PFX4_LEAD, 1, 13, 1'b1));
        card_queue.push_back(make_card(PFX4_LEAD, 1, 13, 1'b0));
        card_queue.push_back(make_card(PFX4_LEAD, 1, 14, 1'b1));
        card_queue.push_back(make_card(PFX4_LEAD, 1, 15, 1'b1));

        // Random: mostly well-formed numbers of each class, mixed with near misses and raw values.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 9);
            good = ($urandom_range(0, 4) != 0);
            case (kind)
                0, 1:
                    card_queue.push_back(make_card($urandom_range(0, 1) ? PFX3X_LOW : PFX3X_HIGH,
                                                   2, LEN_PFX3X, good));
                2, 3:
                    card_queue.push_back(make_card($urandom_range(PFX5X_LOW, PFX5X_HIGH),
                                                   2, LEN_PFX5X, good));
                4:
                    card_queue.push_back(make_card(PFX4_LEAD, 1, LEN_PFX4_LONG, good));
                5:
                    card_queue.push_back(make_card(PFX4_LEAD, 1, LEN_PFX4_SHORT, good));
                6:
                    card_queue.push_back(make_card($urandom_range(30, 59), 2,
                                                   $urandom_range(12, 16), good));
                7:
                begin
                    len = $urandom_range(1, 16);
                    if (len == 1)
                    begin
                        card_queue.push_back(BIN_W'($urandom_range(0, 9)));
                    end
                    else
                    begin
                        card_queue.push_back(make_card($urandom_range(1, 9), 1, len, good));
                    end
                end
                8:
                begin
                    raw = {$urandom, $urandom};
                    card_queue.push_back(raw[BIN_W-1:0]);
                end
                default:
                begin
                    raw = {$urandom, $urandom};
                    card_queue.push_back(BIN_W'(raw % 64'd10_000_000_000_000_000));
                end
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all numbers sent, all results back, then a quiet stretch.
        while (card_queue.size() != 0 || card_bus.valid)
        begin
            @(posedge clk);
        end
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results; %0d failed the checksum.", results_checked,
                 checksum_fails);
        $display("Issuer classes seen: none %0d, 3x %0d, 5x %0d, 4 %0d.", class_seen[0],
                 class_seen[1], class_seen[2], class_seen[3]);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("Timeout with %0d results still expected.", expected_verdicts.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/lcc_pkg.sv
sv/lcc_if.sv
sv/lcc_datapath.sv
sv/lcc_controller.sv
sv/luhn_card_number_check_core.sv
dv/tb_luhn_card_number_check_core.sv
